FILE: src/zpi_pkg.sv
package zpi_pkg;

  localparam int unsigned ZoneW  = 6;
  localparam int unsigned ErrW   = 32;
  localparam int unsigned AreaW  = 24;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LoadW  = 48;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [1:0] OP_EVAL  = 2'd0;
  localparam logic [1:0] OP_INTEG = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_KP       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KI       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_HEAT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_COOL = 2'd3;

  typedef struct packed {
    logic [1:0]             op;
    logic [ZoneW-1:0]       zone;
    logic signed [ErrW-1:0] heating_error;
    logic signed [ErrW-1:0] cooling_error;
    logic [AreaW-1:0]       zone_area;
    logic [TimeW-1:0]       time_now;
  } in_item_t;

  typedef struct packed {
    logic [ZoneW-1:0] zone_out;
    logic [LoadW-1:0] heating_load;
    logic [LoadW-1:0] cooling_load;
  } out_item_t;

  typedef struct packed {
    logic             is_integ;
    logic [ZoneW-1:0] zone;
    logic [ErrW-1:0]  herr;
    logic [ErrW-1:0]  cerr;
    logic [AreaW-1:0] area;
    logic [TimeW-1:0] dt;
  } cmd_t;

  typedef struct packed {
    logic [31:0]      kp;
    logic [31:0]      ki;
    logic [AreaW-1:0] max_heat;
    logic [AreaW-1:0] max_cool;
  } cfg_t;

endpackage

FILE: src/zpi_front.sv
module zpi_front #(
  parameter int unsigned ZONES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  zpi_pkg::in_item_t item_i,
  input  logic             fifo_full_i,
  output logic             fifo_push_o,
  output zpi_pkg::cmd_t    cmd_o
);

  logic [zpi_pkg::TimeW-1:0] last_q, last_d;
  logic accept;
  logic zone_ok;
  logic is_work;

  assign accept  = push_i && !fifo_full_i;
  assign zone_ok = 32'(item_i.zone) < 32'(ZONES);
  assign is_work = (item_i.op == zpi_pkg::OP_EVAL) || (item_i.op == zpi_pkg::OP_INTEG);

  // Elapsed time is fixed at acceptance, so later close beats cannot disturb it.
  always_comb begin
    cmd_o.is_integ = (item_i.op == zpi_pkg::OP_INTEG);
    cmd_o.zone     = item_i.zone;
    cmd_o.herr     = item_i.heating_error;
    cmd_o.cerr     = item_i.cooling_error;
    cmd_o.area     = item_i.zone_area;
    cmd_o.dt       = (item_i.time_now > last_q) ? (item_i.time_now - last_q) : '0;
  end

  assign fifo_push_o = accept && is_work && zone_ok;

  always_comb begin
    last_d = last_q;
    if (accept && (item_i.op == zpi_pkg::OP_CLOSE)) begin
      last_d = item_i.time_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

FILE: src/zpi_cmd_fifo.sv
module zpi_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  zpi_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output zpi_pkg::cmd_t data_o
);

  zpi_pkg::cmd_t entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: src/zpi_engine.sv
module zpi_engine #(
  parameter int unsigned ZONES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  zpi_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  zpi_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               pop_i,
  output zpi_pkg::out_item_t out_o
);

  localparam int unsigned Depth = (ZONES < 64) ? ZONES : 64;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PH, S_PC, S_MPH, S_MPC, S_AH, S_BH, S_AC,
    S_BC, S_UH, S_UC, S_XH, S_YH, S_XC, S_YC, S_OUT
  } state_e;

  function automatic logic signed [47:0] acc_sat(logic signed [47:0] base, logic neg,
                                                 logic [63:0] mag);
    logic [49:0]        pm;
    logic signed [51:0] p;
    logic signed [51:0] s;
    pm = (mag > 64'h2_0000_0000_0000) ? 50'h2_0000_0000_0000 : mag[49:0];
    p  = neg ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
    s  = $signed({{4{base[47]}}, base}) + p;
    if (!s[51] && (s[50:47] != 4'h0)) begin
      return 48'h7FFF_FFFF_FFFF;
    end else if (s[51] && (s[50:47] != 4'hF)) begin
      return 48'h8000_0000_0000;
    end
    return s[47:0];
  endfunction

  function automatic logic [47:0] mag48(logic [47:0] s);
    return s[47] ? (~s + 48'd1) : s;
  endfunction

  // Integral term from the high and low partial products, saturated to 64 bits.
  function automatic logic [63:0] int_term(logic [63:0] a, logic [63:0] bp);
    logic [63:0] b;
    logic [64:0] sum;
    b   = bp >> 8;
    sum = {1'b0, a[47:0], 16'h0} + {1'b0, b};
    if (a[63:48] != 16'h0 || sum[64]) begin
      return '1;
    end
    return sum[63:0];
  endfunction

  function automatic logic [32:0] clamp_sum(logic pneg, logic [63:0] mp, logic ineg,
                                            logic [63:0] mi);
    logic [63:0] one;
    logic [63:0] pos;
    logic [63:0] negv;
    logic [63:0] d;
    one = 64'h1_0000_0000;
    if (!pneg && !ineg) begin
      if (mp >= one || mi >= one) begin
        return one[32:0];
      end
      d = mp + mi;
      return (d > one) ? one[32:0] : d[32:0];
    end
    if (pneg && ineg) begin
      return '0;
    end
    pos  = pneg ? mi : mp;
    negv = pneg ? mp : mi;
    if (pos <= negv) begin
      return '0;
    end
    d = pos - negv;
    return (d > one) ? one[32:0] : d[32:0];
  endfunction

  function automatic logic [47:0] load(logic [32:0] u, logic [47:0] am, logic [63:0] x,
                                       logic [63:0] y);
    logic [63:0] s;
    s = x + (y >> 16);
    if (u[32]) begin
      return {8'h0, am[47:8]};
    end
    return {8'h0, s[63:24]};
  endfunction

  state_e state_q;
  zpi_pkg::cmd_t cmd_q;
  logic [47:0] rd_q;
  logic [Depth-1:0] vld_q;
  logic [47:0] mem_q [Depth];

  logic [63:0] prod_q, prod_d;
  logic [31:0] mul_a, mul_b;
  logic        mul_en;

  logic signed [47:0] sh_q, sc_q;
  logic [63:0] mph_q, mpc_q, ah_q, ac_q, ih_q, ic_q, xh_q, xc_q;
  logic [32:0] uh_q, uc_q;
  logic [47:0] amh_q, amc_q, heat_q;
  zpi_pkg::out_item_t out_q;
  logic        out_vld_q;

  logic [IdxW-1:0]    idx;
  logic signed [47:0] integ;
  logic signed [47:0] sh_new;
  logic [31:0] herr_mag, cerr_mag;
  logic [47:0] sh_mag, sc_mag;
  logic        mem_we;
  logic        out_free;
  logic        out_load;

  assign idx      = cmd_q.zone[IdxW-1:0];
  assign integ    = vld_q[idx] ? rd_q : '0;
  assign herr_mag = cmd_q.herr[31] ? (~cmd_q.herr + 32'd1) : cmd_q.herr;
  assign cerr_mag = cmd_q.cerr[31] ? (~cmd_q.cerr + 32'd1) : cmd_q.cerr;
  assign sh_mag   = mag48(sh_q);
  assign sc_mag   = mag48(sc_q);
  assign sh_new   = acc_sat(integ, cmd_q.herr[31], prod_q);
  assign out_free = !out_vld_q || pop_i;
  assign out_load = (state_q == S_OUT) && out_free;

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  // Integration runs while ki is nonzero and the heating error or the stored integral is positive.
  assign mem_we = (state_q == S_PC) && cmd_q.is_integ && (cfg_i.ki != 32'd0) &&
                  ((!cmd_q.herr[31] && cmd_q.herr != 32'd0) ||
                   (!integ[47] && integ != 48'sd0));

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = (state_q != S_IDLE) && (state_q != S_OUT);
    case (state_q)
      S_PH:  begin mul_a = herr_mag;              mul_b = cmd_q.dt; end
      S_PC:  begin mul_a = cerr_mag;              mul_b = cmd_q.dt; end
      S_MPH: begin mul_a = cfg_i.kp;              mul_b = herr_mag; end
      S_MPC: begin mul_a = cfg_i.kp;              mul_b = cerr_mag; end
      S_AH:  begin mul_a = cfg_i.ki;              mul_b = {8'h0, sh_mag[47:24]}; end
      S_BH:  begin mul_a = cfg_i.ki;              mul_b = {8'h0, sh_mag[23:0]}; end
      S_AC:  begin mul_a = cfg_i.ki;              mul_b = {8'h0, sc_mag[47:24]}; end
      S_BC:  begin mul_a = cfg_i.ki;              mul_b = {8'h0, sc_mag[23:0]}; end
      S_UH:  begin mul_a = {8'h0, cmd_q.area};    mul_b = {8'h0, cfg_i.max_heat}; end
      S_UC:  begin mul_a = {8'h0, cmd_q.area};    mul_b = {8'h0, cfg_i.max_cool}; end
      S_XH:  begin mul_a = uh_q[31:0];            mul_b = amh_q[47:16]; end
      S_YH:  begin mul_a = uh_q[31:0];            mul_b = {16'h0, amh_q[15:0]}; end
      S_XC:  begin mul_a = uc_q[31:0];            mul_b = amc_q[47:16]; end
      S_YC:  begin mul_a = uc_q[31:0];            mul_b = {16'h0, amc_q[15:0]}; end
      default: begin mul_a = '0;                  mul_b = '0; end
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      if (mul_en) begin
        prod_q <= prod_d;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_PH;
          end
        end
        S_PH:  state_q <= S_PC;
        S_PC: begin
          sh_q    <= sh_new;
          state_q <= cmd_q.is_integ ? S_IDLE : S_MPH;
        end
        S_MPH: begin
          sc_q    <= acc_sat(48'sd0, cmd_q.cerr[31], prod_q);
          state_q <= S_MPC;
        end
        S_MPC: begin
          mph_q   <= prod_q;
          state_q <= S_AH;
        end
        S_AH: begin
          mpc_q   <= prod_q;
          state_q <= S_BH;
        end
        S_BH: begin
          ah_q    <= prod_q;
          state_q <= S_AC;
        end
        S_AC: begin
          ih_q    <= int_term(ah_q, prod_q);
          state_q <= S_BC;
        end
        S_BC: begin
          ac_q    <= prod_q;
          state_q <= S_UH;
        end
        S_UH: begin
          ic_q    <= int_term(ac_q, prod_q);
          uh_q    <= clamp_sum(cmd_q.herr[31], mph_q, sh_q[47], ih_q);
          state_q <= S_UC;
        end
        S_UC: begin
          amh_q   <= prod_q[47:0];
          uc_q    <= clamp_sum(cmd_q.cerr[31], mpc_q, sc_q[47], ic_q);
          state_q <= S_XH;
        end
        S_XH: begin
          amc_q   <= prod_q[47:0];
          state_q <= S_YH;
        end
        S_YH: begin
          xh_q    <= prod_q;
          state_q <= S_XC;
        end
        S_XC: begin
          heat_q  <= load(uh_q, amh_q, xh_q, prod_q);
          state_q <= S_YC;
        end
        S_YC: begin
          xc_q    <= prod_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_q.zone_out     <= cmd_q.zone;
            out_q.heating_load <= heat_q;
            out_q.cooling_load <= load(uc_q, amc_q, xc_q, prod_q);
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx] <= sh_new;
    end
    if (cmd_pop_o) begin
      rd_q <= mem_q[cmd_i.zone[IdxW-1:0]];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == S_IDLE)
    else $error("command taken outside idle");
  a_we_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> cmd_q.is_integ && cfg_i.ki != 32'd0)
    else $error("integral written by a non-integrate command");
  a_u_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_XH |-> uh_q <= 33'h1_0000_0000 && uc_q <= 33'h1_0000_0000)
    else $error("control output above one");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_OUT)
    else $error("result loaded outside output state");
`endif

endmodule

FILE: src/zone_pi_heat_cool_load_unit.sv
// Per-zone PI heating/cooling load unit.
// Input channel: present an item on in_i and raise push; a beat is taken at
// a rising edge with push high and full low. Op evaluate yields one result,
// op integrate updates the zone integral, op close records time_now as the
// start of the next step; unused ops and out-of-range zones yield nothing.
// Result channel: while empty is low, out_o holds the oldest result; a beat
// leaves at a rising edge with pop high and empty low.
// Configuration: cfg_we_i, cfg_idx_i and cfg_data_i write kp, ki, max heat
// and max cool per area; write only while the unit is idle.
// Sequencing: a two-entry command queue separates the front from
// a sequencer that shares one 32x32 multiplier. Evaluate steps that
// sequencer through taking the command, 14 products and loading the
// result; integrate takes the command and forms two products, and close
// never enters the queue; later beats wait there until the sequencer is idle.
// Reset clears the configuration to kp 1.0 and zeros elsewhere, clears the
// step time and marks every zone integral as zero. If the receiver stalls,
// one finished result waits in the output register, the sequencer holds the
// next one, and the queue fills before full is raised.
module zone_pi_heat_cool_load_unit #(
  parameter int unsigned ZONES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  zpi_pkg::in_item_t                 in_i,
  output logic                              empty,
  input  logic                              pop,
  output zpi_pkg::out_item_t                out_o,
  input  logic                              cfg_we_i,
  input  logic [zpi_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [zpi_pkg::CfgDataW-1:0]      cfg_data_i
);

  zpi_pkg::cfg_t cfg_q;
  zpi_pkg::cmd_t front_cmd, fifo_cmd;
  logic fifo_push, fifo_full, fifo_empty, fifo_pop;
  logic out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp       <= 32'd65536;
      cfg_q.ki       <= '0;
      cfg_q.max_heat <= '0;
      cfg_q.max_cool <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        zpi_pkg::CFG_KP:       cfg_q.kp       <= cfg_data_i;
        zpi_pkg::CFG_KI:       cfg_q.ki       <= cfg_data_i;
        zpi_pkg::CFG_MAX_HEAT: cfg_q.max_heat <= cfg_data_i[zpi_pkg::AreaW-1:0];
        zpi_pkg::CFG_MAX_COOL: cfg_q.max_cool <= cfg_data_i[zpi_pkg::AreaW-1:0];
        default: ;
      endcase
    end
  end

  zpi_front #(.ZONES(ZONES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_i),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .cmd_o       (front_cmd)
  );

  zpi_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .pop_i   (fifo_pop),
    .data_o  (fifo_cmd)
  );

  zpi_engine #(.ZONES(ZONES)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!fifo_empty),
    .cmd_i       (fifo_cmd),
    .cmd_pop_o   (fifo_pop),
    .out_valid_o (out_valid),
    .pop_i       (pop),
    .out_o       (out_o)
  );

  assign full  = fifo_full;
  assign empty = !out_valid;

endmodule
